FILE: rtl/magnetometer_iron_calibration_macros.svh
// Assertion macros for the magnetometer calibration checker.
`ifndef MAGNETOMETER_IRON_CALIBRATION_MACROS_SVH
`define MAGNETOMETER_IRON_CALIBRATION_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define MIC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define MIC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/mic_pkg.sv
//------------------------------------------------------------------------------
// mic_pkg
// Shared types and constants of the magnetometer calibration block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package mic_pkg;

    // Input operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DROP   = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANGE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_COR_START,
        ST_COR_WAIT,
        ST_OUT
    } mic_state_t;

endpackage

FILE: rtl/magnetometer_iron_calibration.sv
//------------------------------------------------------------------------------
// magnetometer_iron_calibration
// Min/max hard-iron and soft-iron calibration of a three-axis magnetometer.
//------------------------------------------------------------------------------
// Usage: an input item (in_valid/in_ready) is a sample or a drop command.
// A sample yields one result item on out_valid/out_ready; a drop yields none,
// clears the tracked range and the stable level and overwrites the payload.
// The cfg channel writes calibration_enabled; write it only while idle.
// Processing: a disabled sample passes from the range step straight to the
// output register. An enabled sample updates the range, then runs three
// serial multiplications on one shared multiplier, one per axis; before
// them, when the scales are recomputed, it runs three serial divisions on
// one shared divider (an axis with zero span skips its division and keeps
// a scale of 1.0).
// A drop keeps in_ready high, so the next item can be taken the next cycle.
// One item is in work at a time; in_ready is low until the result is taken
// and rises in the cycle after that.
// When the receiver stalls, the result is held in the output register.
// Reset clears range, offsets, level and sets all scales to 1.0 at once.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module magnetometer_iron_calibration
    import mic_pkg::*;
#(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int SCALE_FRAC_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           calibration_enabled,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           operation,
    input  logic [63:0]                    timestamp,
    input  logic signed [SAMPLE_WIDTH-1:0] raw_x,
    input  logic signed [SAMPLE_WIDTH-1:0] raw_y,
    input  logic signed [SAMPLE_WIDTH-1:0] raw_z,
    input  logic [1:0]                     in_level,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [63:0]                    out_timestamp,
    output logic signed [SAMPLE_WIDTH-1:0] cal_x,
    output logic signed [SAMPLE_WIDTH-1:0] cal_y,
    output logic signed [SAMPLE_WIDTH-1:0] cal_z,
    output logic [1:0]                     out_level,
    output logic signed [SAMPLE_WIDTH-1:0] pass_x,
    output logic signed [SAMPLE_WIDTH-1:0] pass_y,
    output logic signed [SAMPLE_WIDTH-1:0] pass_z
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int HW   = SW + 1;              // offset in half units
    localparam int SPW  = SW + 1;              // span width
    localparam int SUMW = SPW + 2;             // sum of three spans
    localparam int DENW = SPW + 2;             // 3 * span
    localparam int NUMW = SUMW + SCALE_FRAC_BITS;
    localparam int SCW  = 8 + SCALE_FRAC_BITS; // scale width
    localparam int PW   = HW + SCW;
    localparam logic [SCW-1:0] SCALE_ONE = SCW'(1) << SCALE_FRAC_BITS;
    localparam logic [SCW-1:0] SCALE_MAX = '1;

    typedef logic signed [SW-1:0] smp_t;
    typedef logic signed [HW-1:0] half_t;

    mic_state_t state_reg, state_next;

    logic        enabled_reg;
    logic        range_valid_reg;
    logic [1:0]  stable_level_reg;
    smp_t        min_reg [3];
    smp_t        max_reg [3];
    half_t       half_reg [3];
    logic [SCW-1:0] scale_reg [3];

    // Item registers.
    logic [63:0] ts_reg;
    smp_t        raw_reg [3];
    smp_t        cal_reg [3];
    logic [1:0]  level_reg;
    logic [1:0]  axis_reg;
    logic        out_valid_reg;

    // Working values of the range step.
    smp_t        new_min [3];
    smp_t        new_max [3];
    half_t       new_half [3];
    logic [1:0]  cnt_same;
    logic        moved;

    logic [SPW-1:0]  span [3];
    logic [SUMW-1:0] span_sum;

    // Shared units.
    logic             div_start, div_done;
    logic [NUMW-1:0]  div_quot;
    logic [NUMW-1:0]  div_num;
    logic [DENW-1:0]  div_den;
    logic             mul_start, mul_done;
    logic [HW-1:0]    mul_a;
    logic [PW-1:0]    mul_prod;

    // Correction operand of the current axis.
    logic signed [HW+1:0] diff2;
    logic signed [HW:0]   dval;
    logic                 d_neg_reg;
    logic [HW-1:0]        mag;
    logic [PW-SCALE_FRAC_BITS-1:0] pshift;
    smp_t                 cal_val;

    mic_divider #(.NUM_WIDTH(NUMW), .DEN_WIDTH(DENW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .numer(div_num), .denom(div_den), .done(div_done), .quot(div_quot)
    );

    mic_multiplier #(.A_WIDTH(HW), .B_WIDTH(SCW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start),
        .a(mul_a), .b(scale_reg[axis_reg]), .done(mul_done), .prod(mul_prod)
    );

    // Range update and offset comparison from the held sample.
    always_comb
    begin
        cnt_same = '0;
        moved    = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (!range_valid_reg)
            begin
                new_min[i] = raw_reg[i];
                new_max[i] = raw_reg[i];
            end
            else
            begin
                new_min[i] = (raw_reg[i] < min_reg[i]) ? raw_reg[i] : min_reg[i];
                new_max[i] = (raw_reg[i] > max_reg[i]) ? raw_reg[i] : max_reg[i];
            end
            new_half[i] = HW'(new_min[i]) + HW'(new_max[i]);
            if (new_half[i] == half_reg[i])
            begin
                cnt_same = cnt_same + 2'd1;
            end
            else
            begin
                moved = 1'b1;
            end
        end
    end

    // Spans from the stored range.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            span[i] = SPW'(HW'(max_reg[i]) - HW'(min_reg[i]));
        end
        span_sum = SUMW'(span[0]) + SUMW'(span[1]) + SUMW'(span[2]);
        div_num  = NUMW'(span_sum) << SCALE_FRAC_BITS;
        div_den  = DENW'(span[axis_reg]) + (DENW'(span[axis_reg]) << 1);
    end

    // Offset-corrected value of the current axis, truncated toward zero.
    always_comb
    begin
        diff2  = ((HW+2)'(raw_reg[axis_reg]) <<< 1) - (HW+2)'(half_reg[axis_reg]);
        dval   = (HW+1)'(diff2 / 2);
        mag    = dval[HW] ? HW'(-dval) : HW'(dval);
        mul_a  = mag;
        pshift = mul_prod[PW-1:SCALE_FRAC_BITS];
        if (d_neg_reg)
        begin
            cal_val = (pshift > (PW-SCALE_FRAC_BITS)'(1) << (SW-1))
                ? {1'b1, {(SW-1){1'b0}}} : SW'(-pshift);
        end
        else
        begin
            cal_val = (pshift > ((PW-SCALE_FRAC_BITS)'(1) << (SW-1)) - 1'b1)
                ? {1'b0, {(SW-1){1'b1}}} : SW'(pshift);
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = (operation == OP_DROP) ? ST_IDLE : ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                if (!enabled_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (stable_level_reg != 2'd3 || moved)
                begin
                    state_next = ST_DIV_START;
                end
                else
                begin
                    state_next = ST_COR_START;
                end
            end
            ST_DIV_START:
            begin
                if (span[axis_reg] == '0)
                begin
                    state_next = (axis_reg == 2'd2) ? ST_COR_START : ST_DIV_START;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (axis_reg == 2'd2) ? ST_COR_START : ST_DIV_START;
                end
            end
            ST_COR_START:
            begin
                mul_start  = 1'b1;
                state_next = ST_COR_WAIT;
            end
            ST_COR_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (axis_reg == 2'd2) ? ST_OUT : ST_COR_START;
                end
            end
            ST_OUT:
            begin
                if (out_valid_reg && out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            enabled_reg      <= 1'b0;
            range_valid_reg  <= 1'b0;
            stable_level_reg <= '0;
            axis_reg         <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i]   <= '0;
                max_reg[i]   <= '0;
                half_reg[i]  <= '0;
                scale_reg[i] <= SCALE_ONE;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                enabled_reg <= calibration_enabled;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    axis_reg <= '0;
                    if (in_valid && in_ready && operation == OP_DROP)
                    begin
                        range_valid_reg  <= 1'b0;
                        stable_level_reg <= '0;
                    end
                end
                ST_RANGE:
                begin
                    if (!enabled_reg)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        range_valid_reg <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            min_reg[i] <= new_min[i];
                            max_reg[i] <= new_max[i];
                        end
                        if (stable_level_reg != 2'd3 || moved)
                        begin
                            stable_level_reg <= cnt_same;
                            for (int i = 0; i < 3; i++)
                            begin
                                half_reg[i] <= new_half[i];
                            end
                        end
                    end
                end
                ST_DIV_START:
                begin
                    if (span[axis_reg] == '0)
                    begin
                        scale_reg[axis_reg] <= SCALE_ONE;
                        axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    end
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        scale_reg[axis_reg] <= (div_quot > NUMW'(SCALE_MAX))
                            ? SCALE_MAX : SCW'(div_quot);
                        axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    end
                end
                ST_COR_START:
                begin
                end
                ST_COR_WAIT:
                begin
                    if (mul_done)
                    begin
                        axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                        if (axis_reg == 2'd2)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            ts_reg     <= timestamp;
            raw_reg[0] <= raw_x;
            raw_reg[1] <= raw_y;
            raw_reg[2] <= raw_z;
            cal_reg[0] <= raw_x;
            cal_reg[1] <= raw_y;
            cal_reg[2] <= raw_z;
            level_reg  <= in_level;
        end
        if (state_reg == ST_RANGE && enabled_reg
            && (stable_level_reg != 2'd3 || moved))
        begin
            level_reg <= cnt_same;
        end
        if (state_reg == ST_COR_START)
        begin
            d_neg_reg <= dval[HW];
        end
        if (state_reg == ST_COR_WAIT && mul_done)
        begin
            cal_reg[axis_reg] <= cal_val;
        end
    end

    assign cfg_ready     = (state_reg == ST_IDLE);
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign out_timestamp = ts_reg;
    assign cal_x         = cal_reg[0];
    assign cal_y         = cal_reg[1];
    assign cal_z         = cal_reg[2];
    assign out_level     = level_reg;
    assign pass_x        = raw_reg[0];
    assign pass_y        = raw_reg[1];
    assign pass_z        = raw_reg[2];

endmodule

FILE: rtl/mic_divider.sv
//------------------------------------------------------------------------------
// mic_divider
// Restoring radix-2 divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module mic_divider
    import mic_pkg::*;
#(
    parameter int NUM_WIDTH = 44,
    parameter int DEN_WIDTH = 28
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] numer,
    input  logic [DEN_WIDTH-1:0] denom,
    output logic                 done,
    output logic [NUM_WIDTH-1:0] quot
);

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] quot_reg, quot_next;
    logic [DEN_WIDTH:0]   rem_reg, rem_next;
    logic [DEN_WIDTH-1:0] den_reg, den_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_WIDTH+1:0] trial;

    // One shift-subtract step per cycle.
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            quot_next = numer;
            rem_next  = '0;
            den_next  = denom;
            cnt_next  = CW'(NUM_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, quot_reg[NUM_WIDTH-1]} - {2'b00, den_reg};
            if (!trial[DEN_WIDTH+1])
            begin
                rem_next  = trial[DEN_WIDTH:0];
                quot_next = {quot_reg[NUM_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[DEN_WIDTH-1:0], quot_reg[NUM_WIDTH-1]};
                quot_next = {quot_reg[NUM_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

FILE: rtl/mic_multiplier.sv
//------------------------------------------------------------------------------
// mic_multiplier
// Shift-add multiplier of a magnitude by an unsigned scale, one bit a cycle.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module mic_multiplier
    import mic_pkg::*;
#(
    parameter int A_WIDTH = 25,
    parameter int B_WIDTH = 24
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [A_WIDTH-1:0]         a,
    input  logic [B_WIDTH-1:0]         b,
    output logic                       done,
    output logic [A_WIDTH+B_WIDTH-1:0] prod
);

    localparam int PW = A_WIDTH + B_WIDTH;
    localparam int CW = $clog2(B_WIDTH + 1);

    logic [PW-1:0]      acc_reg, acc_next;
    logic [PW-1:0]      a_reg, a_next;
    logic [B_WIDTH-1:0] b_reg, b_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    // Add the shifted multiplicand for each set bit of the scale.
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = PW'(a);
            b_next    = b;
            cnt_next  = CW'(B_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[PW-2:0], 1'b0};
            b_next   = {1'b0, b_reg[B_WIDTH-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

FILE: rtl/mic_checker.sv
//------------------------------------------------------------------------------
// mic_checker
// Port-level checks of the magnetometer calibration block.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "magnetometer_iron_calibration_macros.svh"

module mic_checker
    import mic_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       operation,
    input logic       out_valid,
    input logic       out_ready,
    input logic [63:0] out_timestamp
);

    // Result held while stalled.
    `MIC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_timestamp), "result dropped while stalled")

    // No new item while a result waits.
    `MIC_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input taken while result pending")

    // A drop produces no result next cycle.
    `MIC_ASSERT_NEXT(a_drop_silent, clk, rst_n, in_valid && in_ready && operation == OP_DROP, !out_valid, "drop produced a result")

endmodule

bind magnetometer_iron_calibration mic_checker u_mic_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .out_valid(out_valid), .out_ready(out_ready),
    .out_timestamp(out_timestamp)
);
